// ===== rtl/midpoint_ellipse_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasterizer
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define MER_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MER_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_START,
    KIND_STEP
  } item_kind_e;

  typedef struct packed {
    logic       valid;
    item_kind_e kind;
  } q_head_t;

endpackage

// ===== rtl/mer_mul.sv =====
// ----------------------------------------------------------------------------
// mer_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mer_mul #(
  parameter int A_W = 22,
  parameter int B_W = 18
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Accepts input items, tags them as start or step and queues them.
// ----------------------------------------------------------------------------
module mer_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-2:0] radius_x_i,
  input  logic [COORD_BITS-2:0] radius_y_i,
  output mer_pkg::q_head_t      head_o,
  output logic [COORD_BITS-1:0] center_x_o,
  output logic [COORD_BITS-1:0] center_y_o,
  output logic [COORD_BITS-2:0] radius_x_o,
  output logic [COORD_BITS-2:0] radius_y_o,
  input  logic                  pop_i
);
  import mer_pkg::*;

  item_kind_e            kind_mem_q [QDEPTH];
  logic [COORD_BITS-1:0] cx_mem_q   [QDEPTH];
  logic [COORD_BITS-1:0] cy_mem_q   [QDEPTH];
  logic [COORD_BITS-2:0] rx_mem_q   [QDEPTH];
  logic [COORD_BITS-2:0] ry_mem_q   [QDEPTH];

  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           push, pop;
  item_kind_e     in_kind;

  assign in_ready_o = (count_q != QCW'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);
  assign in_kind    = (action_i == ACT_START) ? KIND_START : KIND_STEP;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    count_d  = count_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_mem_q[wr_ptr_q] <= in_kind;
      cx_mem_q[wr_ptr_q]   <= center_x_i;
      cy_mem_q[wr_ptr_q]   <= center_y_i;
      rx_mem_q[wr_ptr_q]   <= radius_x_i;
      ry_mem_q[wr_ptr_q]   <= radius_y_i;
    end
  end

  always_comb begin
    head_o.valid = (count_q != '0);
    head_o.kind  = kind_mem_q[rd_ptr_q];
  end

  assign center_x_o = cx_mem_q[rd_ptr_q];
  assign center_y_o = cy_mem_q[rd_ptr_q];
  assign radius_x_o = rx_mem_q[rd_ptr_q];
  assign radius_y_o = ry_mem_q[rd_ptr_q];

endmodule

// ===== rtl/mer_back.sv =====
// ----------------------------------------------------------------------------
// mer_back
// Executes queued items: geometry set-up, point emission and the
// incremental midpoint decision update, with a registered result.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mer_pkg::q_head_t             head_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [COORD_BITS-2:0]        radius_x_i,
  input  logic [COORD_BITS-2:0]        radius_y_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS+1:0] right_x_o,
  output logic signed [COORD_BITS+1:0] left_x_o,
  output logic signed [COORD_BITS+1:0] lower_y_o,
  output logic signed [COORD_BITS+1:0] upper_y_o,
  output logic                         last_point_o
);
  import mer_pkg::*;

  localparam int R   = COORD_BITS - 1;
  localparam int XW  = R + 1;
  localparam int SQW = 2 * R;
  localparam int STW = 3 * R + 2;
  localparam int RRW = 4 * R;
  localparam int AW  = 2 * R + 4;
  localparam int BW  = 2 * R;
  localparam int PW  = AW + BW;
  localparam int DW  = 4 * R + 7;
  localparam int OW  = COORD_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_INIT2,
    S_INIT3,
    S_INIT4,
    S_EXEC2,
    S_R2_0,
    S_R2_1,
    S_R2_2,
    S_R2_3,
    S_R2_4
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   r2_q, r2_d;
  logic   out_valid_q, out_valid_d;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [R-1:0]          rx_q, ry_q;
  logic [SQW-1:0]        rx2_q, ry2_q;
  logic [RRW-1:0]        rxry_q;
  logic [XW-1:0]         x_q;
  logic [R-1:0]          y_q;
  logic [STW-1:0]        stx_q, sty_q;
  logic [DW-1:0]         d_q;
  logic                  br_q;
  logic [AW-1:0]         t2_q;
  logic [SQW-1:0]        m2_q;

  logic                  mul_en;
  logic [AW-1:0]         mul_a;
  logic [BW-1:0]         mul_b;
  logic [PW-1:0]         mul_p;

  logic                  out_free, out_load, start_go, step_go;
  logic                  neg_d, pos_d, br, inc_x, dec_y;
  logic [XW:0]           tx;
  logic [R-1:0]          ym;
  logic [DW-1:0]         ry2x4, rx2x4, stx4, sty4, d_r1, d_r2;

  mer_mul #(
    .A_W (AW),
    .B_W (BW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign tx = {x_q, 1'b1};
  assign ym = (y_q == '0) ? R'(1) : y_q - R'(1);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_INIT0: begin
        mul_en = 1'b1;
        mul_a  = AW'(rx_q);
        mul_b  = BW'(rx_q);
      end
      S_INIT1: begin
        mul_en = 1'b1;
        mul_a  = AW'(ry_q);
        mul_b  = BW'(ry_q);
      end
      S_INIT2: begin
        mul_en = 1'b1;
        mul_a  = AW'(ry_q);
        mul_b  = rx2_q;
      end
      S_INIT3: begin
        mul_en = 1'b1;
        mul_a  = AW'(ry2_q);
        mul_b  = rx2_q;
      end
      S_R2_0: begin
        mul_en = 1'b1;
        mul_a  = AW'(tx);
        mul_b  = BW'(tx);
      end
      S_R2_1: begin
        mul_en = 1'b1;
        mul_a  = AW'(ym);
        mul_b  = BW'(ym);
      end
      S_R2_2: begin
        mul_en = 1'b1;
        mul_a  = t2_q;
        mul_b  = ry2_q;
      end
      S_R2_3: begin
        mul_en = 1'b1;
        mul_a  = AW'(m2_q);
        mul_b  = rx2_q;
      end
      default: ;
    endcase
  end

  // branch of the current step, taken from the decision before update
  always_comb begin
    neg_d = d_q[DW-1];
    pos_d = !neg_d && (d_q != '0);
    br    = r2_q ? !pos_d : !neg_d;
    inc_x = r2_q ? br : 1'b1;
    dec_y = r2_q ? 1'b1 : br;
  end

  always_comb begin
    ry2x4 = DW'({ry2_q, 2'b00});
    rx2x4 = DW'({rx2_q, 2'b00});
    stx4  = DW'({stx_q, 2'b00});
    sty4  = DW'({sty_q, 2'b00});
    d_r1  = d_q + ry2x4 + stx4 - (br_q ? sty4 : '0);
    d_r2  = d_q + rx2x4 - sty4 + (br_q ? stx4 : '0);
  end

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    start_go = 1'b0;
    step_go  = 1'b0;
    pop_o    = 1'b0;
    out_load = 1'b0;
    if (state_q == S_IDLE && head_i.valid) begin
      if (head_i.kind == KIND_START) begin
        start_go = 1'b1;
        pop_o    = 1'b1;
      end else if (!busy_q) begin
        pop_o = 1'b1;
      end else if (out_free) begin
        pop_o    = 1'b1;
        out_load = 1'b1;
        step_go  = (y_q != '0);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    r2_d        = r2_q;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    unique case (state_q)
      S_IDLE: begin
        if (start_go) begin
          state_d = S_INIT0;
        end else if (step_go) begin
          state_d = S_EXEC2;
        end else if (out_load) begin
          busy_d = 1'b0;
        end
      end
      S_INIT0: state_d = S_INIT1;
      S_INIT1: state_d = S_INIT2;
      S_INIT2: state_d = S_INIT3;
      S_INIT3: begin
        state_d = S_INIT4;
        r2_d    = 1'b0;
      end
      S_INIT4: begin
        state_d = S_IDLE;
        busy_d  = 1'b1;
      end
      S_EXEC2: begin
        state_d = (!r2_q && (stx_q > sty_q)) ? S_R2_0 : S_IDLE;
      end
      S_R2_0: begin
        state_d = S_R2_1;
        r2_d    = 1'b1;
      end
      S_R2_1:  state_d = S_R2_2;
      S_R2_2:  state_d = S_R2_3;
      S_R2_3:  state_d = S_R2_4;
      S_R2_4:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      r2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      r2_q        <= r2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_go) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
    end
    if (out_load) begin
      right_x_o    <= OW'(cx_q) + OW'(x_q);
      left_x_o     <= OW'(cx_q) - OW'(x_q);
      lower_y_o    <= OW'(cy_q) + OW'(y_q);
      upper_y_o    <= OW'(cy_q) - OW'(y_q);
      last_point_o <= (y_q == '0);
    end
    if (step_go) begin
      br_q <= br;
      if (inc_x) begin
        x_q   <= x_q + XW'(1);
        stx_q <= stx_q + STW'({ry2_q, 1'b0});
      end
      if (dec_y) begin
        y_q   <= y_q - R'(1);
        sty_q <= sty_q - STW'({rx2_q, 1'b0});
      end
    end
    unique case (state_q)
      S_INIT1: rx2_q <= mul_p[SQW-1:0];
      S_INIT2: ry2_q <= mul_p[SQW-1:0];
      S_INIT3: begin
        x_q   <= '0;
        y_q   <= ry_q;
        stx_q <= '0;
        sty_q <= STW'({mul_p, 1'b0});
        d_q   <= DW'({ry2_q, 2'b00}) + DW'(rx2_q) - DW'({mul_p, 2'b00});
      end
      S_INIT4: rxry_q <= mul_p[RRW-1:0];
      S_EXEC2: d_q    <= r2_q ? d_r2 : d_r1;
      S_R2_1:  t2_q   <= mul_p[AW-1:0];
      S_R2_2:  m2_q   <= mul_p[SQW-1:0];
      S_R2_3:  d_q    <= DW'(mul_p) - DW'({rxry_q, 2'b00});
      S_R2_4:  d_q    <= d_q + DW'({mul_p, 2'b00});
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `MER_ASSERT_IMP(a_pop_idle, pop_o, state_q == S_IDLE, "queue popped outside dispatch")
  `MER_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, out_ready_i, "pending result overwritten")
  `MER_ASSERT_NXT(a_last_ends, out_load && (y_q == '0), !busy_q, "trace still busy after last point")
  `MER_ASSERT_NXT(a_r2_entry, state_q == S_R2_4, r2_q && busy_q, "region two not entered")

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse trace for an axis-aligned ellipse, four points per step.
// ----------------------------------------------------------------------------
// Input items enter a two-entry queue, so the input side keeps accepting
// while the execution side works or waits on a result. A start item is
// dispatched and then steps through S_INIT0 to S_INIT4 on the shared
// (2*COORD_BITS+2) x (2*COORD_BITS-2) multiplier that forms the squared
// radii and their products. A step item has its result registered at
// dispatch and the decision advanced in the next cycle, in S_EXEC2; the
// step that gives the last point of a trace only registers its result. The
// one step at which the trace crosses into region two then goes through
// S_R2_0 to S_R2_4 on the multiplier to seed the region-two decision. A step
// while no ellipse is active is dropped at dispatch. Results wait in an
// output register; a step stalls while it is full and unread or while busy.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [COORD_BITS-2:0]        radius_x_i,
  input  logic [COORD_BITS-2:0]        radius_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS+1:0] right_x_o,
  output logic signed [COORD_BITS+1:0] left_x_o,
  output logic signed [COORD_BITS+1:0] lower_y_o,
  output logic signed [COORD_BITS+1:0] upper_y_o,
  output logic                         last_point_o
);
  import mer_pkg::*;

  q_head_t               head;
  logic                  pop;
  logic [COORD_BITS-1:0] q_cx, q_cy;
  logic [COORD_BITS-2:0] q_rx, q_ry;

  mer_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_x_i (radius_x_i),
    .radius_y_i (radius_y_i),
    .head_o     (head),
    .center_x_o (q_cx),
    .center_y_o (q_cy),
    .radius_x_o (q_rx),
    .radius_y_o (q_ry),
    .pop_i      (pop)
  );

  mer_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .center_x_i   (q_cx),
    .center_y_i   (q_cy),
    .radius_x_i   (q_rx),
    .radius_y_i   (q_ry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .right_x_o    (right_x_o),
    .left_x_o     (left_x_o),
    .lower_y_o    (lower_y_o),
    .upper_y_o    (upper_y_o),
    .last_point_o (last_point_o)
  );

endmodule

// ===== tb/mer_point_checker.sv =====
// ----------------------------------------------------------------------------
// mer_point_checker
// Watches both channels of the ellipse rasterizer, traces the ellipse from the
// accepted input items and checks each accepted point set in arrival order.
// ----------------------------------------------------------------------------
module mer_point_checker #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         action_i,
  input  logic [COORD_BITS-1:0]        center_x_i,
  input  logic [COORD_BITS-1:0]        center_y_i,
  input  logic [COORD_BITS-2:0]        radius_x_i,
  input  logic [COORD_BITS-2:0]        radius_y_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [COORD_BITS+1:0] right_x_i,
  input  logic signed [COORD_BITS+1:0] left_x_i,
  input  logic signed [COORD_BITS+1:0] lower_y_i,
  input  logic signed [COORD_BITS+1:0] upper_y_i,
  input  logic                         last_point_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int OW          = COORD_BITS + 2;
  localparam int SQW         = 2 * COORD_BITS - 2;
  localparam int DW          = 4 * COORD_BITS + 2;
  localparam int SW          = 4 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS+1:0] right_x;
    logic signed [COORD_BITS+1:0] left_x;
    logic signed [COORD_BITS+1:0] lower_y;
    logic signed [COORD_BITS+1:0] upper_y;
    logic                         last_point;
  } point_set_t;

  logic [COORD_BITS-1:0]          off_x;
  logic [COORD_BITS-1:0]          off_y;
  logic                           in_region_two;
  logic                           tracing;
  logic signed [4*COORD_BITS+1:0] decision;
  logic signed [4*COORD_BITS-1:0] slope_x;
  logic signed [4*COORD_BITS-1:0] slope_y;
  logic [2*COORD_BITS-3:0]        rx_sq;
  logic [2*COORD_BITS-3:0]        ry_sq;
  logic [COORD_BITS-1:0]          ctr_col;
  logic [COORD_BITS-1:0]          ctr_row;

  point_set_t expected_points[$];
  point_set_t want_ps;
  point_set_t got_ps;
  point_set_t new_ps;
  bit         new_emits;
  int         mismatch_cnt = 0;
  int         pending_cnt  = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  task automatic trace_item(input logic act, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy,
                            input logic [COORD_BITS-2:0] rx,
                            input logic [COORD_BITS-2:0] ry,
                            output bit emits, output point_set_t ps);
    longint rxl, ryl, rxs, rys, dec, sx, sy, ox, oy, tx, ym;
    emits = 1'b0;
    ps    = '0;
    if (act == ACT_START) begin
      rxl           = longint'(rx);
      ryl           = longint'(ry);
      rxs           = rxl * rxl;
      rys           = ryl * ryl;
      ctr_col       = cx;
      ctr_row       = cy;
      rx_sq         = SQW'(rxs);
      ry_sq         = SQW'(rys);
      off_x         = '0;
      off_y         = COORD_BITS'(ry);
      slope_x       = '0;
      slope_y       = SW'(2 * rxs * ryl);
      decision      = DW'(4 * rys - 4 * rxs * ryl + rxs);
      in_region_two = 1'b0;
      tracing       = 1'b1;
    end else if (tracing) begin
      ox            = longint'(off_x);
      oy            = longint'(off_y);
      rxs           = longint'(rx_sq);
      rys           = longint'(ry_sq);
      dec           = longint'(decision);
      sx            = longint'(slope_x);
      sy            = longint'(slope_y);
      emits         = 1'b1;
      ps.right_x    = OW'(longint'(ctr_col) + ox);
      ps.left_x     = OW'(longint'(ctr_col) - ox);
      ps.lower_y    = OW'(longint'(ctr_row) + oy);
      ps.upper_y    = OW'(longint'(ctr_row) - oy);
      ps.last_point = (oy == 0);
      if (oy == 0) begin
        tracing = 1'b0;
      end else if (!in_region_two) begin
        ox = ox + 1;
        sx = sx + 2 * rys;
        if (dec < 0) begin
          dec = dec + 4 * (rys + sx);
        end else begin
          oy  = oy - 1;
          sy  = sy - 2 * rxs;
          dec = dec + 4 * (rys + sx - sy);
        end
        if (sx > sy) begin
          tx            = 2 * ox + 1;
          ym            = oy - 1;
          in_region_two = 1'b1;
          dec           = rys * tx * tx + 4 * rxs * ym * ym - 4 * rxs * rys;
        end
      end else begin
        oy = oy - 1;
        sy = sy - 2 * rxs;
        if (dec > 0) begin
          dec = dec + 4 * (rxs - sy);
        end else begin
          ox  = ox + 1;
          sx  = sx + 2 * rys;
          dec = dec + 4 * (rxs - sy + sx);
        end
      end
      off_x    = COORD_BITS'(ox);
      off_y    = COORD_BITS'(oy);
      decision = DW'(dec);
      slope_x  = SW'(sx);
      slope_y  = SW'(sy);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x         = '0;
      off_y         = '0;
      in_region_two = 1'b0;
      tracing       = 1'b0;
      decision      = '0;
      slope_x       = '0;
      slope_y       = '0;
      rx_sq         = '0;
      ry_sq         = '0;
      ctr_col       = '0;
      ctr_row       = '0;
      expected_points.delete();
      pending_cnt   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_ps = '{right_x_i, left_x_i, lower_y_i, upper_y_i, last_point_i};
        if (expected_points.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("%0t: unexpected point set rx=%0d lx=%0d ly=%0d uy=%0d last=%0b",
                     $realtime, got_ps.right_x, got_ps.left_x, got_ps.lower_y,
                     got_ps.upper_y, got_ps.last_point);
          end
          mismatch_cnt++;
        end else begin
          want_ps = expected_points.pop_front();
          if (got_ps.right_x !== want_ps.right_x || got_ps.left_x !== want_ps.left_x ||
              got_ps.lower_y !== want_ps.lower_y || got_ps.upper_y !== want_ps.upper_y ||
              got_ps.last_point !== want_ps.last_point) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("%0t: point mismatch expected rx=%0d lx=%0d ly=%0d uy=%0d last=%0b",
                       $realtime, want_ps.right_x, want_ps.left_x, want_ps.lower_y,
                       want_ps.upper_y, want_ps.last_point);
              $display("%0t:                  actual rx=%0d lx=%0d ly=%0d uy=%0d last=%0b",
                       $realtime, got_ps.right_x, got_ps.left_x, got_ps.lower_y,
                       got_ps.upper_y, got_ps.last_point);
            end
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        trace_item(action_i, center_x_i, center_y_i, radius_x_i, radius_y_i,
                   new_emits, new_ps);
        if (new_emits) begin
          expected_points.push_back(new_ps);
        end
      end
      pending_cnt = expected_points.size();
    end
  end

endmodule

// ===== tb/tb_midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer
// Drives start and step items into the ellipse rasterizer: directed corner
// geometries first, then random ellipses traced to the end, broken traces and
// stray steps, with random idling on both channels, a long output hold-off
// and drain pauses. The checker beside the block scores every point set.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int CB             = 10;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  logic                 action;
  logic [CB-1:0]        center_x;
  logic [CB-1:0]        center_y;
  logic [CB-2:0]        radius_x;
  logic [CB-2:0]        radius_y;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CB+1:0] right_x;
  logic signed [CB+1:0] left_x;
  logic signed [CB+1:0] lower_y;
  logic signed [CB+1:0] upper_y;
  logic                 last_point;

  int mismatches;
  int pending;
  int item_cnt      = 0;
  int idle_cycles   = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  bit idle_enable   = 1'b1;
  bit hold_request  = 1'b0;

  midpoint_ellipse_rasterizer #(
    .COORD_BITS(CB)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_x_i  (radius_x),
    .radius_y_i  (radius_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .right_x_o   (right_x),
    .left_x_o    (left_x),
    .lower_y_o   (lower_y),
    .upper_y_o   (upper_y),
    .last_point_o(last_point)
  );

  mer_point_checker #(
    .COORD_BITS(CB)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .action_i    (action),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_x_i  (radius_x),
    .radius_y_i  (radius_y),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .right_x_i   (right_x),
    .left_x_i    (left_x),
    .lower_y_i   (lower_y),
    .upper_y_i   (upper_y),
    .last_point_i(last_point),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        out_ready    <= 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("** midpoint_ellipse_rasterizer: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_item(input logic act, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                           input logic [CB-2:0] rx, input logic [CB-2:0] ry);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    center_x <= cx;
    center_y <= cy;
    radius_x <= rx;
    radius_y <= ry;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    item_cnt++;
  endtask

  task automatic start_ellipse(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                               input logic [CB-2:0] rx, input logic [CB-2:0] ry);
    send_item(ACT_START, cx, cy, rx, ry);
  endtask

  // step payload beside the action is don't-care, so it is randomized
  task automatic step_points(input int n);
    repeat (n) send_item(ACT_STEP, CB'($urandom), CB'($urandom),
                         (CB-1)'($urandom), (CB-1)'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [CB-1:0] cx, cy;
    logic [CB-2:0] rx, ry;
    int            pick, seq_no, rand_base, large_left;

    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    action   <= ACT_START;
    center_x <= '0;
    center_y <= '0;
    radius_x <= '0;
    radius_y <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // step with no ellipse active
    step_points(1);
    // largest radii around the origin: negative left and upper coordinates
    start_ellipse(0, 0, 511, 511);
    step_points(2);
    // restart while busy, smallest ellipse at the far corner, run past its end
    start_ellipse(1023, 1023, 1, 1);
    step_points(4);
    // zero horizontal radius, with the center on the left edge
    start_ellipse(0, 1023, 0, 5);
    step_points(8);
    // zero vertical radius: first point is the last
    start_ellipse(512, 512, 5, 0);
    step_points(2);
    start_ellipse(7, 7, 0, 0);
    step_points(1);

    // back-pressure: hold the output while steps keep coming, then drain
    idle_enable = 1'b0;
    start_ellipse(100, 100, 30, 30);
    hold_request = 1'b1;
    step_points(25);
    wait_drained();
    idle_enable = 1'b1;

    rand_base  = item_cnt;
    seq_no     = 0;
    large_left = 3;
    while (item_cnt - rand_base < RANDOM_ITEMS) begin
      if (item_cnt - rand_base > RANDOM_ITEMS * 7 / 8) idle_enable = 1'b0;
      cx   = CB'($urandom);
      cy   = CB'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        step_points($urandom_range(1, 3));
      end else if (pick == 1) begin
        rx = (CB-1)'($urandom);
        ry = (CB-1)'($urandom);
        start_ellipse(cx, cy, rx, ry);
        step_points($urandom_range(1, 30));
      end else if (pick == 2 && large_left > 0 && item_cnt - rand_base < RANDOM_ITEMS / 2) begin
        large_left--;
        if ($urandom_range(0, 1) == 0) begin
          rx = (CB-1)'($urandom_range(256, 511));
          ry = (CB-1)'($urandom_range(0, 7));
        end else begin
          rx = (CB-1)'($urandom_range(0, 7));
          ry = (CB-1)'($urandom_range(256, 511));
        end
        start_ellipse(cx, cy, rx, ry);
        step_points(int'(rx) + int'(ry) + 2);
      end else begin
        rx = (CB-1)'($urandom_range(0, 40));
        ry = (CB-1)'($urandom_range(0, 40));
        start_ellipse(cx, cy, rx, ry);
        step_points(int'(rx) + int'(ry) + 2 + $urandom_range(0, 1));
      end
      seq_no++;
      if (seq_no % 16 == 0) wait_drained();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("** midpoint_ellipse_rasterizer: PASSED **");
    end else begin
      $display("** midpoint_ellipse_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_mul.sv
rtl/mer_front.sv
rtl/mer_back.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/mer_point_checker.sv
tb/tb_midpoint_ellipse_rasterizer.sv
